### src/assert_macros.svh
// Assertion macros of the page table walker, included by its controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/ptw_pkg.sv
// Shared constants, codes and word types of the page table walker.
package ptw_pkg;

    // Table store geometry.
    localparam int TABLE_FRAMES      = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int FRAME_W           = $clog2(TABLE_FRAMES);
    localparam int STORE_WORDS       = TABLE_FRAMES * ENTRIES_PER_TABLE;
    localparam int STORE_ADDR_W      = FRAME_W + IDX_W;

    // Entry masks and flag bits.
    localparam logic [63:0] FRAME_MASK  = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] HUGE_MASK   = 64'h000F_FFFF_FFE0_0000;
    localparam logic [63:0] FLAG_MASK   = 64'hFFF0_0000_0000_0FFF;
    localparam logic [63:0] BIT_PRESENT = 64'h0000_0000_0000_0001;
    localparam logic [63:0] BIT_HUGE    = 64'h0000_0000_0000_0080;

    // Operation codes.
    localparam logic [2:0] OP_WRITE      = 3'd0;
    localparam logic [2:0] OP_TRANSLATE  = 3'd1;
    localparam logic [2:0] OP_READ_FLAGS = 3'd2;
    localparam logic [2:0] OP_UPDATE     = 3'd3;
    localparam logic [2:0] OP_UNMAP      = 3'd4;

    // Status codes.
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_ABSENT = 2'd1;
    localparam logic [1:0] STAT_RANGE  = 2'd2;

    // Source of the store read address.
    typedef enum logic [1:0] {
        RS_ROOT = 2'd0,
        RS_PDPT = 2'd1,
        RS_PD   = 2'd2,
        RS_PT   = 2'd3
    } t_rd_sel;

    // Source of the store write address and data.
    typedef enum logic [1:0] {
        WS_CLEAR = 2'd0,
        WS_WORD  = 2'd1,
        WS_LEAF  = 2'd2
    } t_wr_sel;

    // Request word.
    typedef struct packed {
        logic [2:0]  op;
        logic [47:0] virt_addr;
        logic [12:0] word_addr;
        logic [63:0] write_data;
        logic [63:0] set_flags;
    } t_ptw_in;

    // Result word.
    typedef struct packed {
        logic [51:0] phys_addr;
        logic [63:0] leaf_flags;
        logic [1:0]  status;
    } t_ptw_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       wr_en;
        t_wr_sel    wr_sel;
        logic       leaf_huge;
        logic       finish;
        logic [1:0] status;
    } t_ptw_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] new_op;
        logic [2:0] op;
        logic       root_bad;
        logic       present;
        logic       huge;
        logic       frame_bad;
        logic       waddr_ok;
        logic       clr_last;
    } t_ptw_stat;

endpackage

### src/ptw_ctrl.sv
// Controller state machine of the page table walker.
`include "assert_macros.svh"

module ptw_ctrl
    import ptw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_ptw_stat i_stat,
    output t_ptw_cmd  o_cmd,
    output logic      o_busy
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_WORD  = 7'b0000100,
        S_L4    = 7'b0001000,
        S_L3    = 7'b0010000,
        S_L2    = 7'b0100000,
        S_L1    = 7'b1000000
    } t_ptw_state;

    t_ptw_state r_state;
    t_ptw_state n_state;
    logic       leaf;
    logic       leaf_huge;

    // State register; reset starts the clearing pass over the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // Next state and commands.
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RS_ROOT;
        o_cmd.wr_sel = WS_CLEAR;
        o_cmd.status = STAT_DONE;
        n_state      = r_state;
        leaf         = 1'b0;
        leaf_huge    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_ROOT;
                    if (i_stat.new_op == OP_TRANSLATE || i_stat.new_op == OP_READ_FLAGS ||
                        i_stat.new_op == OP_UPDATE || i_stat.new_op == OP_UNMAP) begin
                        n_state = S_L4;
                    end else begin
                        n_state = S_WORD;
                    end
                end
            end
            S_WORD: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
                if (i_stat.op == OP_WRITE) begin
                    if (i_stat.waddr_ok) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = WS_WORD;
                    end else begin
                        o_cmd.status = STAT_RANGE;
                    end
                end
            end
            S_L4: begin
                if (i_stat.root_bad) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = STAT_RANGE;
                    n_state      = S_IDLE;
                end else if (!i_stat.present) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = STAT_ABSENT;
                    n_state      = S_IDLE;
                end else if (i_stat.frame_bad) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = STAT_RANGE;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_PDPT;
                    n_state      = S_L3;
                end
            end
            S_L3: begin
                if (!i_stat.present) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = STAT_ABSENT;
                    n_state      = S_IDLE;
                end else if (i_stat.frame_bad) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = STAT_RANGE;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_PD;
                    n_state      = S_L2;
                end
            end
            S_L2: begin
                if (!i_stat.present) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = STAT_ABSENT;
                    n_state      = S_IDLE;
                end else if (i_stat.huge) begin
                    leaf      = 1'b1;
                    leaf_huge = 1'b1;
                end else if (i_stat.frame_bad) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = STAT_RANGE;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_PT;
                    n_state      = S_L1;
                end
            end
            S_L1: begin
                leaf = 1'b1;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // Work on the leaf entry, either a 2 MB directory entry or a 4 KB entry.
        if (leaf) begin
            o_cmd.leaf_huge = leaf_huge;
            o_cmd.finish    = 1'b1;
            n_state         = S_IDLE;
            case (i_stat.op)
                OP_TRANSLATE: begin
                    if (!(leaf_huge || i_stat.present)) begin
                        o_cmd.status = STAT_ABSENT;
                    end
                end
                OP_UPDATE: begin
                    if (leaf_huge || i_stat.present) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = WS_LEAF;
                    end else begin
                        o_cmd.status = STAT_ABSENT;
                    end
                end
                OP_UNMAP: begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WS_LEAF;
                end
                default: begin
                end
            endcase
        end
    end

    // A finished word always returns the controller to idle.
    `ASSERT_CLKRST(a_finish_idle, i_clk, i_rst_n, o_cmd.finish |=> r_state == S_IDLE, "finish did not return to idle")
    // Idle is entered only after a finished word or the end of the clearing pass.
    `ASSERT_CLKRST(a_idle_entry, i_clk, i_rst_n, (r_state == S_IDLE && $past(r_state) != S_IDLE) |-> ($past(o_cmd.finish) || $past(i_stat.clr_last)), "idle entered without cause")
    // Every walk level checks data from a store read issued in the cycle before.
    `ASSERT_CLKRST(a_level_read, i_clk, i_rst_n, (r_state == S_L4 || r_state == S_L3 || r_state == S_L2 || r_state == S_L1) |-> $past(o_cmd.rd_en), "walk level without a store read")
    // The store is never read and written in the same cycle.
    `ASSERT_CLKRST(a_no_rw, i_clk, i_rst_n, o_cmd.wr_en |-> !o_cmd.rd_en, "store read and written together")

endmodule

### src/ptw_datapath.sv
// Datapath of the page table walker: table store, request and result registers.
module ptw_datapath
    import ptw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ptw_in    i_req,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  t_ptw_cmd   i_cmd,
    output t_ptw_stat  o_stat,
    output t_ptw_out   o_result,
    output logic       o_result_valid
);

    logic [63:0]             r_store [STORE_WORDS];
    logic [63:0]             r_rdata;
    logic [STORE_ADDR_W-1:0] r_leaf_addr;
    logic [STORE_ADDR_W-1:0] r_clr_cnt;
    logic [3:0]              r_root;
    t_ptw_in                 r_req;
    t_ptw_out                r_res;
    t_ptw_out                n_res;
    logic                    r_res_valid;

    logic [31:0]             root_ext;
    logic [31:0]             waddr_ext;
    logic [FRAME_W-1:0]      rd_frame;
    logic [IDX_W-1:0]        rd_idx;
    logic [STORE_ADDR_W-1:0] rd_addr;
    logic [STORE_ADDR_W-1:0] wr_addr;
    logic [63:0]             wr_data;
    logic [63:0]             leaf_data;

    // Root frame register, written from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= 4'd0;
        end else if (i_cfg_we) begin
            r_root <= i_cfg_wdata;
        end
    end

    // Request word captured on acceptance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.wr_en && i_cmd.wr_sel == WS_CLEAR) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign root_ext  = 32'(r_root);
    assign waddr_ext = 32'(r_req.word_addr);

    // Read address: the root frame or the frame named by the entry just read.
    always_comb begin
        rd_frame = r_rdata[12 +: FRAME_W];
        rd_idx   = i_req.virt_addr[47:39];
        case (i_cmd.rd_sel)
            RS_ROOT: begin
                rd_frame = root_ext[FRAME_W-1:0];
                rd_idx   = i_req.virt_addr[47:39];
            end
            RS_PDPT: rd_idx = r_req.virt_addr[38:30];
            RS_PD:   rd_idx = r_req.virt_addr[29:21];
            RS_PT:   rd_idx = r_req.virt_addr[20:12];
            default: rd_idx = r_req.virt_addr[20:12];
        endcase
        rd_addr = {rd_frame, rd_idx};
    end

    // New leaf entry for the update and unmap operations.
    always_comb begin
        leaf_data = '0;
        if (r_req.op == OP_UPDATE) begin
            if (i_cmd.leaf_huge) begin
                leaf_data = (r_rdata & HUGE_MASK) | r_req.set_flags | BIT_PRESENT | BIT_HUGE;
            end else begin
                leaf_data = (r_rdata & FRAME_MASK) | r_req.set_flags | BIT_PRESENT;
            end
        end
    end

    // Write address and data.
    always_comb begin
        case (i_cmd.wr_sel)
            WS_CLEAR: begin
                wr_addr = r_clr_cnt;
                wr_data = '0;
            end
            WS_WORD: begin
                wr_addr = waddr_ext[STORE_ADDR_W-1:0];
                wr_data = r_req.write_data;
            end
            WS_LEAF: begin
                wr_addr = r_leaf_addr;
                wr_data = leaf_data;
            end
            default: begin
                wr_addr = r_leaf_addr;
                wr_data = leaf_data;
            end
        endcase
    end

    // Table store with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata     <= r_store[rd_addr];
            r_leaf_addr <= rd_addr;
        end
    end

    // Status for the controller.
    always_comb begin
        o_stat.new_op    = i_req.op;
        o_stat.op        = r_req.op;
        o_stat.root_bad  = (root_ext >= 32'(TABLE_FRAMES));
        o_stat.present   = r_rdata[0];
        o_stat.huge      = r_rdata[7];
        o_stat.frame_bad = (r_rdata[51:12] >= 40'(TABLE_FRAMES));
        o_stat.waddr_ok  = (waddr_ext < 32'(STORE_WORDS));
        o_stat.clr_last  = (r_clr_cnt == STORE_ADDR_W'(STORE_WORDS - 1));
    end

    // Result word; address and flags are shown only on success.
    always_comb begin
        n_res.status     = i_cmd.status;
        n_res.phys_addr  = '0;
        n_res.leaf_flags = '0;
        if (i_cmd.status == STAT_DONE) begin
            if (r_req.op == OP_TRANSLATE) begin
                if (i_cmd.leaf_huge) begin
                    n_res.phys_addr = {r_rdata[51:21], r_req.virt_addr[20:0]};
                end else begin
                    n_res.phys_addr = {r_rdata[51:12], r_req.virt_addr[11:0]};
                end
            end
            if (r_req.op == OP_READ_FLAGS) begin
                n_res.leaf_flags = r_rdata & FLAG_MASK;
            end
        end
    end

    // Result register and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    assign o_result       = r_res;
    assign o_result_valid = r_res_valid;

endmodule

### src/four_level_page_table_walker.sv
// Top level of the four-level page table walker.
//
// A request word is taken at a rising edge where start is high and busy is low.
// A table write or an unknown operation keeps the block busy in the word state
// after acceptance; a walk keeps it busy in one state per table level that it
// reads (L4, L3, L2 and L1 for a full 4 KB walk, L4 to L2 for a 2 MB leaf), and
// a fault ends the walk at the level where it is found. The walk is paced by the
// chain of dependent table reads through the single read port of the table
// store; a leaf write-back happens in the cycle that checks the leaf. The result
// word appears on o_result the cycle after the walk ends, with o_result_valid
// high for exactly that one cycle, and must be taken then: it cannot be held
// off. A new request may be accepted in the same cycle. After reset the block
// clears all TABLE_FRAMES * ENTRIES_PER_TABLE words (8192 as built) of the table
// store, one word per cycle, with busy high; root frame writes are taken during
// that pass.
module four_level_page_table_walker
    import ptw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_ptw_in    i_req,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    output t_ptw_out   o_result,
    output logic       o_result_valid
);

    t_ptw_cmd  cmd;
    t_ptw_stat stat;

    // Controller.
    ptw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Datapath with the table store.
    ptw_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule
